// ----- src/planar_angle_unwrap_tracker_macros.svh -----
// Assertion macros shared by the planar angle unwrap tracker.
`ifndef PLANAR_ANGLE_UNWRAP_TRACKER_MACROS_SVH
`define PLANAR_ANGLE_UNWRAP_TRACKER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PAUT_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define PAUT_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- src/paut_pkg.sv -----
// Types, constants and helper functions of the planar angle unwrap tracker.
`default_nettype none
package paut_pkg;

  localparam int CordicSteps = 32;
  localparam int AtanSlots   = 60;
  localparam int AtanIdxW    = $clog2(AtanSlots);
  localparam int DivBits     = 53;
  localparam int MulSteps    = 8;
  localparam int MulStepW    = $clog2(MulSteps);
  localparam int UnwBits     = 16;

  localparam logic signed [63:0] PiQ60        = 64'sh3243F6A8885A308D;
  localparam logic signed [63:0] HalfPiQ60    = 64'sh1921FB54442D1847;
  localparam logic signed [63:0] QuarterPiQ60 = 64'sh0C90FDAA22168C23;
  localparam logic signed [63:0] ThreeHalfPiQ60 = 64'sh4B65F1FCCC8748D4;
  localparam logic signed [63:0] TwoPiQ60     = 64'sh6487ED5110B4611A;
  localparam logic signed [63:0] RoundQ28     = 64'sh0000000008000000;
  localparam logic [34:0]        TwoPiQ32     = 35'h6487ED511;
  localparam logic [35:0]        FourPiQ32    = 36'hC90FDAA22;

  typedef enum logic {
    ACT_INIT   = 1'b0,
    ACT_UPDATE = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_ZERO = 2'd1,
    STAT_SAT  = 2'd2
  } status_e;

  typedef enum logic [MulStepW-1:0] {
    MS_XX  = 3'd0,
    MS_YY  = 3'd1,
    MS_XY  = 3'd2,
    MS_SQ  = 3'd3,
    MS_P00 = 3'd4,
    MS_P01 = 3'd5,
    MS_P10 = 3'd6,
    MS_P11 = 3'd7
  } mul_step_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_ITER,
    ST_UNW_PREP,
    ST_UNWRAP,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic               action;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
  } in_beat_t;

  typedef struct packed {
    logic signed [47:0] angle;
    logic signed [47:0] cos_over_rsq;
    logic signed [47:0] sin_over_rsq;
    logic signed [47:0] two_cos_sin_term;
    logic signed [47:0] diff_squares_term;
    logic [1:0]         status;
  } out_beat_t;

  typedef struct packed {
    logic                load_in;
    logic                mul_en;
    mul_step_e           mul_step;
    logic                iter_load;
    logic                div_step;
    logic                cordic_step;
    logic [AtanIdxW-1:0] cordic_idx;
    logic                unw_prep;
    logic                unw_step;
    logic                commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic signed [47:0] val;
    logic               sat;
  } quot_res_t;

  typedef logic [AtanSlots-1:0][63:0] atan_tab_t;

  // Division of a power of two by one of the odd series denominators.
  function automatic logic [63:0] odd_div(input logic [63:0] p, input int unsigned k);
    logic [63:0] q;
    case (k)
      0: q = p / 64'd1;    1: q = p / 64'd3;    2: q = p / 64'd5;
      3: q = p / 64'd7;    4: q = p / 64'd9;    5: q = p / 64'd11;
      6: q = p / 64'd13;   7: q = p / 64'd15;   8: q = p / 64'd17;
      9: q = p / 64'd19;   10: q = p / 64'd21;  11: q = p / 64'd23;
      12: q = p / 64'd25;  13: q = p / 64'd27;  14: q = p / 64'd29;
      15: q = p / 64'd31;  16: q = p / 64'd33;  17: q = p / 64'd35;
      18: q = p / 64'd37;  19: q = p / 64'd39;  20: q = p / 64'd41;
      21: q = p / 64'd43;  22: q = p / 64'd45;  23: q = p / 64'd47;
      24: q = p / 64'd49;  25: q = p / 64'd51;  26: q = p / 64'd53;
      27: q = p / 64'd55;  28: q = p / 64'd57;  29: q = p / 64'd59;
      default: q = '0;
    endcase
    return q;
  endfunction

  // Arctangent of 2^-i in Q3.60: pi/4 for i = 0, else from the truncated Taylor series.
  function automatic atan_tab_t build_atan();
    atan_tab_t   tab;
    int          e;
    logic [63:0] sum;
    logic [63:0] term;
    for (int i = 0; i < AtanSlots; i++) begin
      if (i == 0) begin
        tab[i] = QuarterPiQ60;
      end else begin
        sum = '0;
        for (int unsigned k = 0; k < 30; k++) begin
          e = 60 - i * (2 * int'(k) + 1);
          if (e >= 0) begin
            term = odd_div(64'd1 << e, k);
            if ((k & 1) == 1) begin
              sum = sum - term;
            end else begin
              sum = sum + term;
            end
          end
        end
        tab[i] = sum;
      end
    end
    return tab;
  endfunction

  // Rounds a doubled quotient to nearest and clamps it to the signed 48-bit range.
  function automatic quot_res_t sat_round(input logic [DivBits-1:0] quot, input logic ovf,
                                          input logic neg);
    quot_res_t          r;
    logic [DivBits:0]   sum;
    logic [DivBits-1:0] m;
    logic [DivBits-1:0] limit;
    sum   = {1'b0, quot} + {{DivBits{1'b0}}, 1'b1};
    m     = sum[DivBits:1];
    limit = neg ? DivBits'(48'h8000_0000_0000) : DivBits'(48'h7FFF_FFFF_FFFF);
    r.sat = 1'b0;
    if (ovf || (m > limit)) begin
      m     = limit;
      r.sat = 1'b1;
    end
    r.val = neg ? -$signed(m[47:0]) : $signed(m[47:0]);
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/paut_divlane.sv -----
// One radix-2 restoring divider lane producing a 53-bit quotient.
`default_nettype none
module paut_divlane (
  input  wire logic                           clk_i,
  input  wire logic                           load_i,
  input  wire logic                           step_i,
  input  wire logic [127:0]                   hi_i,
  input  wire logic [paut_pkg::DivBits-1:0]   lo_i,
  input  wire logic [127:0]                   den_i,
  output logic      [paut_pkg::DivBits-1:0]   quot_o,
  output logic                                ovf_o
);

  logic [127:0]                 rem_q, rem_d;
  logic [paut_pkg::DivBits-1:0] lo_q, lo_d;
  logic [paut_pkg::DivBits-1:0] quot_q, quot_d;
  logic                         ovf_q, ovf_d;
  logic [127:0]                 trial;
  logic                         fits;

  always_comb begin
    trial  = {rem_q[126:0], lo_q[paut_pkg::DivBits-1]};
    fits   = trial >= den_i;
    rem_d  = rem_q;
    lo_d   = lo_q;
    quot_d = quot_q;
    ovf_d  = ovf_q;
    if (load_i) begin
      rem_d  = hi_i;
      lo_d   = lo_i;
      quot_d = '0;
      // The quotient would need more than the lane's bits.
      ovf_d  = hi_i >= den_i;
    end else if (step_i) begin
      rem_d  = fits ? (trial - den_i) : trial;
      lo_d   = {lo_q[paut_pkg::DivBits-2:0], 1'b0};
      quot_d = {quot_q[paut_pkg::DivBits-2:0], fits};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    lo_q   <= lo_d;
    quot_q <= quot_d;
    ovf_q  <= ovf_d;
  end

  assign quot_o = quot_q;
  assign ovf_o  = ovf_q;

endmodule
`default_nettype wire

// ----- src/paut_ctrl.sv -----
// Sequencer of the planar angle unwrap tracker: steps the datapath through each item.
`default_nettype none
module paut_ctrl #(
  parameter int CORDIC_STEPS = paut_pkg::CordicSteps
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire paut_pkg::dp_status_t   status_i,
  output paut_pkg::cmd_t              cmd_o
);

  localparam int IterLen = (CORDIC_STEPS > paut_pkg::DivBits) ? CORDIC_STEPS
                                                              : paut_pkg::DivBits;
  localparam int CntW = $clog2(IterLen + 1);
  localparam logic [CntW-1:0] MulLast  = CntW'(paut_pkg::MulSteps - 1);
  localparam logic [CntW-1:0] IterLast = CntW'(IterLen - 1);
  localparam logic [CntW-1:0] UnwLast  = CntW'(paut_pkg::UnwBits - 1);
  localparam logic [CntW-1:0] DivLen   = CntW'(paut_pkg::DivBits);
  localparam logic [CntW-1:0] CordLen  = CntW'(CORDIC_STEPS);

  paut_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      paut_pkg::ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) state_d = paut_pkg::ST_MUL;
      end
      paut_pkg::ST_MUL: begin
        if (cnt_q == MulLast) begin
          state_d = paut_pkg::ST_LOAD;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      paut_pkg::ST_LOAD: begin
        state_d = paut_pkg::ST_ITER;
        cnt_d   = '0;
      end
      paut_pkg::ST_ITER: begin
        if (cnt_q == IterLast) begin
          state_d = paut_pkg::ST_UNW_PREP;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      paut_pkg::ST_UNW_PREP: begin
        state_d = paut_pkg::ST_UNWRAP;
        cnt_d   = '0;
      end
      paut_pkg::ST_UNWRAP: begin
        if (cnt_q == UnwLast) begin
          state_d = paut_pkg::ST_FINISH;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      paut_pkg::ST_FINISH: begin
        if (status_i.out_free) state_d = paut_pkg::ST_IDLE;
      end
      default: begin
        state_d = paut_pkg::ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_comb begin
    in_ready_o        = 1'b0;
    cmd_o             = '0;
    cmd_o.mul_step    = paut_pkg::mul_step_e'(cnt_q[paut_pkg::MulStepW-1:0]);
    cmd_o.cordic_idx  = cnt_q[paut_pkg::AtanIdxW-1:0];
    case (state_q)
      paut_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      paut_pkg::ST_MUL:      cmd_o.mul_en = 1'b1;
      paut_pkg::ST_LOAD:     cmd_o.iter_load = 1'b1;
      paut_pkg::ST_ITER: begin
        cmd_o.div_step    = cnt_q < DivLen;
        cmd_o.cordic_step = cnt_q < CordLen;
      end
      paut_pkg::ST_UNW_PREP: cmd_o.unw_prep = 1'b1;
      paut_pkg::ST_UNWRAP:   cmd_o.unw_step = 1'b1;
      paut_pkg::ST_FINISH:   cmd_o.commit = status_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= paut_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ----- src/paut_datapath.sv -----
// Datapath: shared multiplier, CORDIC vectoring unit, divider lanes, unwrap and result register.
`default_nettype none
module paut_datapath (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire paut_pkg::in_beat_t     in_data_i,
  input  wire paut_pkg::cmd_t         cmd_i,
  output paut_pkg::dp_status_t        status_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output paut_pkg::out_beat_t         out_data_o
);

  localparam paut_pkg::atan_tab_t AtanTab = paut_pkg::build_atan();
  localparam logic signed [52:0] ResMax = 53'sd140737488355327;
  localparam logic signed [52:0] ResMin = -53'sd140737488355328;

  // Captured item.
  logic        act_q, xneg_q, yneg_q;
  logic [31:0] xm_q, ym_q;
  logic [31:0] xin, yin;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      act_q  <= in_data_i.action;
      xneg_q <= xin[31];
      yneg_q <= yin[31];
      xm_q   <= xin[31] ? (~xin + 32'd1) : xin;
      ym_q   <= yin[31] ? (~yin + 32'd1) : yin;
    end
  end

  assign xin = in_data_i.x_coord;
  assign yin = in_data_i.y_coord;

  // Shared 32x32 multiplier for x^2, y^2, xy and for the square of r^2.
  logic [63:0]  xx_q, yy_q, xy_q, sq_q;
  logic [127:0] den_q;
  logic [31:0]  mul_a, mul_b;
  logic [63:0]  prod;

  always_comb begin
    case (cmd_i.mul_step)
      paut_pkg::MS_XX:  begin mul_a = xm_q;         mul_b = xm_q;         end
      paut_pkg::MS_YY:  begin mul_a = ym_q;         mul_b = ym_q;         end
      paut_pkg::MS_XY:  begin mul_a = xm_q;         mul_b = ym_q;         end
      paut_pkg::MS_P00: begin mul_a = sq_q[31:0];   mul_b = sq_q[31:0];   end
      paut_pkg::MS_P01: begin mul_a = sq_q[31:0];   mul_b = sq_q[63:32];  end
      paut_pkg::MS_P10: begin mul_a = sq_q[63:32];  mul_b = sq_q[31:0];   end
      paut_pkg::MS_P11: begin mul_a = sq_q[63:32];  mul_b = sq_q[63:32];  end
      default:          begin mul_a = '0;           mul_b = '0;           end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_step)
        paut_pkg::MS_XX:  xx_q <= prod;
        paut_pkg::MS_YY:  yy_q <= prod;
        paut_pkg::MS_XY:  xy_q <= prod;
        paut_pkg::MS_SQ:  sq_q <= xx_q + yy_q;
        paut_pkg::MS_P00: den_q <= {64'd0, prod};
        paut_pkg::MS_P01: den_q <= den_q + {32'd0, prod, 32'd0};
        paut_pkg::MS_P10: den_q <= den_q + {32'd0, prod, 32'd0};
        paut_pkg::MS_P11: den_q <= den_q + {prod, 64'd0};
        default: ;
      endcase
    end
  end

  // Divider lanes: x/r^2, y/r^2, 2xy/r^4 and (y^2-x^2)/r^4.
  logic [63:0]                  ndiff;
  logic                         neg_d;
  logic [paut_pkg::DivBits-1:0] q_c, q_s, q_t, q_d;
  logic                         ovf_c, ovf_s, ovf_t, ovf_d;

  assign neg_d = xx_q > yy_q;
  assign ndiff = (yy_q >= xx_q) ? (yy_q - xx_q) : (xx_q - yy_q);

  paut_divlane u_div_c (
    .clk_i, .load_i(cmd_i.iter_load), .step_i(cmd_i.div_step),
    .hi_i({100'd0, xm_q[31:4]}), .lo_i({xm_q[3:0], 49'd0}),
    .den_i({64'd0, sq_q}), .quot_o(q_c), .ovf_o(ovf_c)
  );

  paut_divlane u_div_s (
    .clk_i, .load_i(cmd_i.iter_load), .step_i(cmd_i.div_step),
    .hi_i({100'd0, ym_q[31:4]}), .lo_i({ym_q[3:0], 49'd0}),
    .den_i({64'd0, sq_q}), .quot_o(q_s), .ovf_o(ovf_s)
  );

  paut_divlane u_div_t (
    .clk_i, .load_i(cmd_i.iter_load), .step_i(cmd_i.div_step),
    .hi_i({51'd0, xy_q, 13'd0}), .lo_i('0),
    .den_i(den_q), .quot_o(q_t), .ovf_o(ovf_t)
  );

  paut_divlane u_div_d (
    .clk_i, .load_i(cmd_i.iter_load), .step_i(cmd_i.div_step),
    .hi_i({52'd0, ndiff, 12'd0}), .lo_i('0),
    .den_i(den_q), .quot_o(q_d), .ovf_o(ovf_d)
  );

  // CORDIC vectoring, one micro-rotation per cycle. For x < 0 the vector is
  // mirrored so that pi plus the phase gives the 0..2pi direction.
  logic signed [63:0] cx_q, cy_q, cz_q;
  logic signed [63:0] ym_ext, dx, dy, atan_e;

  assign ym_ext = $signed({3'b000, ym_q, 29'd0});
  assign dx     = cy_q >>> cmd_i.cordic_idx;
  assign dy     = cx_q >>> cmd_i.cordic_idx;
  assign atan_e = $signed(AtanTab[cmd_i.cordic_idx]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.iter_load) begin
      cx_q <= $signed({3'b000, xm_q, 29'd0});
      cy_q <= (xneg_q ^ yneg_q) ? -ym_ext : ym_ext;
      cz_q <= '0;
    end else if (cmd_i.cordic_step) begin
      if (!cy_q[63]) begin
        cx_q <= cx_q + dx;
        cy_q <= cy_q - dy;
        cz_q <= cz_q + atan_e;
      end else begin
        cx_q <= cx_q - dx;
        cy_q <= cy_q + dy;
        cz_q <= cz_q - atan_e;
      end
    end
  end

  // Direction in 0..2pi and the initial angle, rounded to Q3.32.
  logic signed [63:0] a02, initv, a02r, initr;
  logic signed [35:0] a32_c, i32_c;

  always_comb begin
    if (xm_q == '0) begin
      a02   = yneg_q ? paut_pkg::ThreeHalfPiQ60 : paut_pkg::HalfPiQ60;
      initv = a02;
    end else if (ym_q == '0) begin
      a02   = xneg_q ? paut_pkg::PiQ60 : '0;
      initv = a02;
    end else if (!xneg_q) begin
      initv = cz_q;
      a02   = cz_q[63] ? (cz_q + paut_pkg::TwoPiQ60) : cz_q;
    end else begin
      a02   = paut_pkg::PiQ60 + cz_q;
      initv = a02;
    end
  end

  assign a02r  = a02 + paut_pkg::RoundQ28;
  assign initr = initv + paut_pkg::RoundQ28;
  assign a32_c = a02r[63:28];
  assign i32_c = initr[63:28];

  // Turn count: round(|d| / 2pi), found one quotient bit per cycle.
  logic signed [47:0] tracked_q, tracked_d;
  logic signed [35:0] a32_q, i32_q;
  logic               dneg_q;
  logic [50:0]        num_q, dv_q;
  logic [15:0]        nt_q;
  logic signed [48:0] ang_diff;
  logic [48:0]        adist;
  logic               num_ge;

  assign ang_diff = {tracked_q[47], tracked_q} - {{13{a32_c[35]}}, a32_c};
  assign adist    = ang_diff[48] ? (~ang_diff + 49'd1) : ang_diff;
  assign num_ge   = num_q >= dv_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.unw_prep) begin
      a32_q  <= a32_c;
      i32_q  <= i32_c;
      dneg_q <= ang_diff[48];
      num_q  <= {1'b0, adist, 1'b0} + {16'd0, paut_pkg::TwoPiQ32};
      dv_q   <= {paut_pkg::FourPiQ32, 15'd0};
      nt_q   <= '0;
    end else if (cmd_i.unw_step) begin
      if (num_ge) num_q <= num_q - dv_q;
      dv_q <= {1'b0, dv_q[50:1]};
      nt_q <= {nt_q[14:0], num_ge};
    end
  end

  // Final angle and result assembly.
  logic [50:0]         turn;
  logic signed [52:0]  res;
  logic signed [47:0]  res48;
  logic                ang_sat, zero_vec;
  paut_pkg::quot_res_t r_c, r_s, r_t, r_d;
  paut_pkg::out_beat_t beat;

  assign turn     = nt_q * paut_pkg::TwoPiQ32;
  assign zero_vec = (xm_q == '0) && (ym_q == '0);

  always_comb begin
    res     = dneg_q ? ({{17{a32_q[35]}}, a32_q} - $signed({2'b00, turn}))
                     : ({{17{a32_q[35]}}, a32_q} + $signed({2'b00, turn}));
    ang_sat = 1'b0;
    res48   = res[47:0];
    if (res > ResMax) begin
      res48   = ResMax[47:0];
      ang_sat = 1'b1;
    end else if (res < ResMin) begin
      res48   = ResMin[47:0];
      ang_sat = 1'b1;
    end
  end

  assign r_c = paut_pkg::sat_round(q_c, ovf_c, xneg_q);
  assign r_s = paut_pkg::sat_round(q_s, ovf_s, yneg_q);
  assign r_t = paut_pkg::sat_round(q_t, ovf_t, xneg_q ^ yneg_q);
  assign r_d = paut_pkg::sat_round(q_d, ovf_d, neg_d);

  always_comb begin
    if (zero_vec) begin
      tracked_d = (act_q == paut_pkg::ACT_INIT) ? '0 : tracked_q;
    end else if (act_q == paut_pkg::ACT_INIT) begin
      tracked_d = {{12{i32_q[35]}}, i32_q};
    end else begin
      tracked_d = res48;
    end
    beat.angle = tracked_d;
    if (zero_vec) begin
      beat.cos_over_rsq      = '0;
      beat.sin_over_rsq      = '0;
      beat.two_cos_sin_term  = '0;
      beat.diff_squares_term = '0;
      beat.status            = paut_pkg::STAT_ZERO;
    end else begin
      beat.cos_over_rsq      = r_c.val;
      beat.sin_over_rsq      = r_s.val;
      beat.two_cos_sin_term  = r_t.val;
      beat.diff_squares_term = r_d.val;
      // An angle clamp only counts on an update item.
      if (r_c.sat || r_s.sat || r_t.sat || r_d.sat ||
          (ang_sat && (act_q == paut_pkg::ACT_UPDATE))) begin
        beat.status = paut_pkg::STAT_SAT;
      end else begin
        beat.status = paut_pkg::STAT_OK;
      end
    end
  end

  logic                out_valid_q;
  paut_pkg::out_beat_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tracked_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        tracked_q   <= tracked_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) out_q <= beat;
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule
`default_nettype wire

// ----- src/planar_angle_unwrap_tracker.sv -----
// Top level of the planar angle unwrap tracker.
// Each beat carries a Q16.16 vector and an action: initialize sets the tracked angle from
// the vector's direction, update adds the whole number of turns that lands the 0..2pi
// direction nearest the tracked angle. An item passes from acceptance to its result beat
// through the shared 32x32 multiplier, a load step, the four radix-2 divider lanes (the
// CORDIC micro-rotations run alongside them), the turn count and a commit step, which waits
// until the output register is free. A new item is taken only once the previous result
// sits in the output register, which holds it until taken, so items never overlap.
`default_nettype none
`include "planar_angle_unwrap_tracker_macros.svh"
module planar_angle_unwrap_tracker #(
  parameter int CORDIC_STEPS = paut_pkg::CordicSteps
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire paut_pkg::in_beat_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output paut_pkg::out_beat_t       out_data_o
);

  paut_pkg::cmd_t       cmd;
  paut_pkg::dp_status_t dp_status;

  paut_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .status_i(dp_status),
    .cmd_o(cmd)
  );

  paut_datapath u_datapath (
    .clk_i,
    .rst_ni,
    .in_data_i,
    .cmd_i(cmd),
    .status_o(dp_status),
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

  `PAUT_ASSERT_CLK(a_accept_blocks_next, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o, "input accepted while an item is in work")
  `PAUT_ASSERT_NEVER(a_commit_overwrites, clk_i, rst_ni, cmd.commit && out_valid_o && !out_ready_i, "result overwrote an untaken beat")
  `PAUT_ASSERT_NEVER(a_zero_quotients, clk_i, rst_ni, out_valid_o && out_data_o.status == paut_pkg::STAT_ZERO && out_data_o.cos_over_rsq != '0, "zero vector with nonzero quotient")

endmodule
`default_nettype wire
